// File: hdl/angle_to_speed_estimator_unit_macros.svh
// ----------------------------------------------------------------------------
// angle_to_speed_estimator_unit_macros.svh
// assertion macros for the speed estimator rtl
// ----------------------------------------------------------------------------
`ifndef ANGLE_TO_SPEED_ESTIMATOR_UNIT_MACROS_SVH
`define ANGLE_TO_SPEED_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/ase_pkg.sv
// ----------------------------------------------------------------------------
// ase_pkg
// shared widths, register indexes, controller states and command structs
// ----------------------------------------------------------------------------
package ase_pkg;

    // angle resolution, counts per revolution is 2^ANGLE_BITS
    localparam int ANGLE_BITS = 12;
    localparam int TIME_W     = 32;

    // configuration registers
    localparam int GAIN_W     = 17;
    localparam int LIMIT_W    = 24;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD  = 2'd3;

    localparam logic [GAIN_W-1:0]   RST_FILTER_GAIN = 17'd6554;
    localparam logic [LIMIT_W-1:0]  RST_SPEED_LIMIT = 24'd1310720;
    localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD  = 8'd1;
    localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD  = 8'd100;

    // wrapped angle step lives in [-half turn, +half turn]
    localparam int DELTA_W = ANGLE_BITS + 1;
    localparam logic signed [DELTA_W-1:0] DELTA_HALF = DELTA_W'(1 << (ANGLE_BITS - 1));
    localparam logic signed [DELTA_W-1:0] DELTA_FULL = DELTA_W'(1 << ANGLE_BITS);

    // half turn times the scale is always 1000 * 2^16, which needs 26 bits
    localparam int NUM_W = 26;
    localparam logic [NUM_W-1:0] SPEED_SCALE = NUM_W'(2000 << (16 - ANGLE_BITS));
    localparam int CNT_W = $clog2(NUM_W);

    // filter arithmetic
    localparam int SPEED_W = 25;
    localparam int DIFF_W  = NUM_W + 2;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int SHIFT_W = PROD_W - 16;
    localparam int SUM_W   = SHIFT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCALE,
        S_DIV,
        S_MUL,
        S_FILT,
        S_FIRST
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic scale;
        logic div_step;
        logic mul;
        logic filt;
        logic first;
    } t_cmd;

    typedef struct packed {
        logic primed;
    } t_status;

endpackage

// File: hdl/angle_to_speed_estimator_unit.sv
// ----------------------------------------------------------------------------
// angle_to_speed_estimator_unit
// shaft speed from angle and timestamp samples, smoothed by a first-order iir
//
//   channel   direction  handshake           payload
//   sample    in         i_valid / o_ready   i_angle_count, i_time_ms
//   speed     out        o_valid / i_ready   o_speed, o_limited
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// a sample passes from acceptance to result through these steps: preparing period
// and step, scaling, 26 steps of the restoring divider, a multiply and the
// filter; the first sample after reset answers zero right after preparation.
// one sample is in work at a time; the next is taken once the result is loaded.
// a result waiting on i_ready does not block the next sample, only its loading.
// synchronous active-low reset restores the register defaults and clears history.
// ----------------------------------------------------------------------------
`include "angle_to_speed_estimator_unit_macros.svh"

module angle_to_speed_estimator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ase_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ase_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ase_pkg::ANGLE_BITS-1:0]     i_angle_count,
    input  logic [ase_pkg::TIME_W-1:0]         i_time_ms,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ase_pkg::SPEED_W-1:0] o_speed,
    output logic                               o_limited
);
    import ase_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    ase_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // arithmetic and state
    ase_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_angle_count (i_angle_count),
        .i_time_ms     (i_time_ms),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_speed       (o_speed),
        .o_limited     (o_limited)
    );

    // checks
    `ASE_ASSERT_NEXT(a_one_item_in_work, i_valid && o_ready, !o_ready)
    `ASE_ASSERT_SAME(a_no_result_overwrite, w_cmd.filt || w_cmd.first, !o_valid || i_ready)
    `ASE_ASSERT_NEXT(a_first_result_zero, w_cmd.first, o_valid && o_speed == '0 && !o_limited)
    `ASE_ASSERT_SAME(a_first_only_unprimed, w_cmd.first, !w_status.primed)

endmodule

// File: hdl/ase_ctrl.sv
// ----------------------------------------------------------------------------
// ase_ctrl
// sequencer for one sample: prepare, scale, serial divide, multiply, filter, output
// ----------------------------------------------------------------------------
module ase_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  ase_pkg::t_status i_status,
    output ase_pkg::t_cmd   o_cmd
);
    import ase_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    // output register can take a new result
    assign w_out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PREP;
            S_PREP:  n_state = i_status.primed ? S_SCALE : S_FIRST;
            S_SCALE: n_state = S_DIV;
            S_DIV:   if (r_count == LAST_STEP) n_state = S_MUL;
            S_MUL:   n_state = S_FILT;
            S_FILT:  if (w_out_free) n_state = S_IDLE;
            S_FIRST: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd    = '0;
        o_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            S_PREP:  o_cmd.prep     = 1'b1;
            S_SCALE: o_cmd.scale    = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_MUL:   o_cmd.mul      = 1'b1;
            S_FILT:  o_cmd.filt     = w_out_free;
            S_FIRST: o_cmd.first    = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    // divide step counter
    always_comb begin
        n_count = r_count;
        if (o_cmd.scale) begin
            n_count = '0;
        end else if (o_cmd.div_step) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.filt || o_cmd.first) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/ase_datapath.sv
// ----------------------------------------------------------------------------
// ase_datapath
// configuration registers, sample history, restoring divider and iir filter
// ----------------------------------------------------------------------------
module ase_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ase_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ase_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [ase_pkg::ANGLE_BITS-1:0]     i_angle_count,
    input  logic [ase_pkg::TIME_W-1:0]         i_time_ms,
    input  ase_pkg::t_cmd                      i_cmd,
    output ase_pkg::t_status                   o_status,
    output logic signed [ase_pkg::SPEED_W-1:0] o_speed,
    output logic                               o_limited
);
    import ase_pkg::*;

    // configuration
    logic [GAIN_W-1:0]   r_gain;
    logic [LIMIT_W-1:0]  r_limit;
    logic [PERIOD_W-1:0] r_min_period;
    logic [PERIOD_W-1:0] r_max_period;

    // history and working registers
    logic                      r_primed;
    logic [ANGLE_BITS-1:0]     r_in_angle, r_prior_angle;
    logic [TIME_W-1:0]         r_in_time, r_prior_time;
    logic signed [SPEED_W-1:0] r_smoothed;
    logic [PERIOD_W-1:0]       r_period;
    logic signed [DELTA_W-1:0] r_delta;
    logic                      r_neg;
    logic [NUM_W-1:0]          r_quo;
    logic [PERIOD_W-1:0]       r_rem;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SPEED_W-1:0] r_speed;
    logic                      r_limited;

    // period and angle step
    logic [TIME_W-1:0]         w_tdiff;
    logic [TIME_W:0]           w_per_raw, w_per_lo;
    logic [PERIOD_W-1:0]       w_lo, w_hi, w_period;
    logic signed [DELTA_W-1:0] w_draw, w_delta;

    // scaling and division
    logic [DELTA_W-1:0]        w_abs;
    logic [ANGLE_BITS-1:0]     w_mag;
    logic [NUM_W-1:0]          w_num;
    logic [PERIOD_W:0]         w_trial;
    logic                      w_ge;

    // filter
    logic signed [NUM_W:0]     w_inst;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SHIFT_W-1:0] w_shift;
    logic signed [SUM_W-1:0]   w_sum, w_lim, w_filt;
    logic                      w_clamped;

    // elapsed time in half milliseconds, clamped low then high
    assign w_tdiff   = r_in_time - r_prior_time;
    assign w_per_raw = {w_tdiff, 1'b0};
    assign w_lo      = (r_min_period == '0) ? PERIOD_W'(1) : r_min_period;
    assign w_hi      = (r_max_period == '0) ? PERIOD_W'(1) : r_max_period;
    assign w_per_lo  = (w_per_raw < {{(TIME_W + 1 - PERIOD_W){1'b0}}, w_lo})
                     ? {{(TIME_W + 1 - PERIOD_W){1'b0}}, w_lo} : w_per_raw;
    assign w_period  = (w_per_lo > {{(TIME_W + 1 - PERIOD_W){1'b0}}, w_hi})
                     ? w_hi : w_per_lo[PERIOD_W-1:0];

    // angle step wrapped to half a turn either way
    assign w_draw  = $signed({1'b0, r_in_angle}) - $signed({1'b0, r_prior_angle});
    always_comb begin
        w_delta = w_draw;
        if (w_draw > DELTA_HALF) begin
            w_delta = w_draw - DELTA_FULL;
        end else if (w_draw < -DELTA_HALF) begin
            w_delta = w_draw + DELTA_FULL;
        end
    end

    // magnitude of the numerator, sign kept apart
    assign w_abs = r_delta[DELTA_W-1] ? DELTA_W'(-r_delta) : DELTA_W'(r_delta);
    assign w_mag = w_abs[ANGLE_BITS-1:0];
    assign w_num = {{(NUM_W - ANGLE_BITS){1'b0}}, w_mag} * SPEED_SCALE;

    // one restoring divide step
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_period});

    // instant speed and weighted difference
    assign w_inst = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_diff = DIFF_W'(w_inst) - DIFF_W'(r_smoothed);
    assign w_prod = w_diff * $signed({1'b0, r_gain});

    // floor shift, accumulate and clamp
    assign w_shift = r_prod[PROD_W-1:16];
    assign w_sum   = SUM_W'(w_shift) + SUM_W'(r_smoothed);
    assign w_lim   = $signed({{(SUM_W - LIMIT_W){1'b0}}, r_limit});
    always_comb begin
        w_filt    = w_sum;
        w_clamped = 1'b0;
        if (w_sum > w_lim) begin
            w_filt    = w_lim;
            w_clamped = 1'b1;
        end else if (w_sum < -w_lim) begin
            w_filt    = -w_lim;
            w_clamped = 1'b1;
        end
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= RST_FILTER_GAIN;
            r_limit      <= RST_SPEED_LIMIT;
            r_min_period <= RST_MIN_PERIOD;
            r_max_period <= RST_MAX_PERIOD;
            r_primed     <= 1'b0;
            r_smoothed   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FILTER_GAIN: r_gain       <= i_cfg_data[GAIN_W-1:0];
                    REG_SPEED_LIMIT: r_limit      <= i_cfg_data[LIMIT_W-1:0];
                    REG_MIN_PERIOD:  r_min_period <= i_cfg_data[PERIOD_W-1:0];
                    REG_MAX_PERIOD:  r_max_period <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.first) begin
                r_primed <= 1'b1;
            end
            if (i_cmd.filt) begin
                r_smoothed <= w_filt[SPEED_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_angle <= i_angle_count;
            r_in_time  <= i_time_ms;
        end
        if (i_cmd.prep) begin
            r_period <= w_period;
            r_delta  <= w_delta;
        end
        if (i_cmd.scale) begin
            r_quo <= w_num;
            r_rem <= '0;
            r_neg <= r_delta[DELTA_W-1];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? PERIOD_W'(w_trial - {1'b0, r_period})
                          : w_trial[PERIOD_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.filt || i_cmd.first) begin
            r_prior_angle <= r_in_angle;
            r_prior_time  <= r_in_time;
        end
        if (i_cmd.filt) begin
            r_speed   <= w_filt[SPEED_W-1:0];
            r_limited <= w_clamped;
        end else if (i_cmd.first) begin
            r_speed   <= '0;
            r_limited <= 1'b0;
        end
    end

    assign o_status.primed = r_primed;
    assign o_speed         = r_speed;
    assign o_limited       = r_limited;

endmodule

// File: tb/angle_to_speed_estimator_unit_test.sv
// ----------------------------------------------------------------------------
// angle_to_speed_estimator_unit_test
// self-checking bench for the shaft speed estimator: a scoreboard predicts the
// filtered, clamped speed of every accepted sample and checks each result in
// order, while the driver runs directed corner cases and random sample streams
// under several register settings with random idling on both channels
// ----------------------------------------------------------------------------
module angle_to_speed_estimator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ase_pkg::*;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic [ANGLE_BITS-1:0]        i_angle_count;
    logic [TIME_W-1:0]            i_time_ms;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [SPEED_W-1:0]    o_speed;
    logic                         o_limited;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      limited;
    } t_speed_result;

    // expected speed results and a private copy of the estimator state
    class speed_scoreboard;
        logic [GAIN_W-1:0]     gain;
        logic [LIMIT_W-1:0]    limit;
        logic [PERIOD_W-1:0]   min_per;
        logic [PERIOD_W-1:0]   max_per;
        logic                  primed;
        logic [ANGLE_BITS-1:0] prev_angle;
        logic [TIME_W-1:0]     prev_time;
        longint                filtered;
        t_speed_result         expected_speeds[$];
        int                    mismatches;
        int                    samples;
        int                    clamps;

        function new();
            gain       = RST_FILTER_GAIN;
            limit      = RST_SPEED_LIMIT;
            min_per    = RST_MIN_PERIOD;
            max_per    = RST_MAX_PERIOD;
            primed     = 1'b0;
            prev_angle = '0;
            prev_time  = '0;
            filtered   = 0;
            mismatches = 0;
            samples    = 0;
            clamps     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FILTER_GAIN: gain    = data[GAIN_W-1:0];
                REG_SPEED_LIMIT: limit   = data[LIMIT_W-1:0];
                REG_MIN_PERIOD:  min_per = data[PERIOD_W-1:0];
                REG_MAX_PERIOD:  max_per = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        // works out the result of one accepted sample
        function void note_sample(logic [ANGLE_BITS-1:0] angle, logic [TIME_W-1:0] now_ms);
            logic [TIME_W-1:0] dt;
            longint            per;
            longint            lo;
            longint            hi;
            longint            step;
            longint            inst;
            longint            f;
            longint            lim;
            longint            full;
            t_speed_result     res;
            full = longint'(1) << ANGLE_BITS;
            samples++;
            res.limited = 1'b0;
            if (!primed) begin
                // first sample only records history and answers zero
                primed     = 1'b1;
                prev_angle = angle;
                prev_time  = now_ms;
                res.speed  = '0;
                expected_speeds.push_back(res);
                return;
            end
            // elapsed time in half milliseconds, zero limits act as one
            dt  = now_ms - prev_time;
            per = longint'(dt) * 2;
            lo  = (min_per == 0) ? 1 : longint'(min_per);
            hi  = (max_per == 0) ? 1 : longint'(max_per);
            if (per < lo) per = lo;
            if (per > hi) per = hi;
            // angle step wrapped to half a turn either way
            step = longint'(angle) - longint'(prev_angle);
            if (step > full / 2) step -= full;
            if (step < -(full / 2)) step += full;
            inst = (step * (longint'(2000) << (16 - ANGLE_BITS))) / per;
            // low-pass with a flooring shift, then the symmetric clamp
            f   = filtered + (((inst - filtered) * longint'(gain)) >>> 16);
            lim = longint'(limit);
            if (f > lim) begin
                f = lim;
                res.limited = 1'b1;
            end
            if (f < -lim) begin
                f = -lim;
                res.limited = 1'b1;
            end
            if (res.limited) clamps++;
            filtered   = f;
            prev_angle = angle;
            prev_time  = now_ms;
            res.speed  = f[SPEED_W-1:0];
            expected_speeds.push_back(res);
        endfunction

        // compares one delivered result with the oldest expectation
        function void check_speed(logic signed [SPEED_W-1:0] speed, logic limited);
            t_speed_result exp_res;
            if (expected_speeds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: speed %0d limited %0b", speed, limited);
                return;
            end
            exp_res = expected_speeds.pop_front();
            if (exp_res.speed !== speed || exp_res.limited !== limited) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0b, got %0d/%0b",
                             exp_res.speed, exp_res.limited, speed, limited);
            end
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction
    endclass

    speed_scoreboard       sb;
    logic                  calm;
    int                    stall_left;
    int                    settings;
    logic [ANGLE_BITS-1:0] sent_angle;
    logic [TIME_W-1:0]     sent_time;

    angle_to_speed_estimator_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_angle_count(i_angle_count),
        .i_time_ms    (i_time_ms),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_speed      (o_speed),
        .o_limited    (o_limited)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(10_000_000);
        $display("angle_to_speed_estimator_unit_test: errors");
        $finish;
    end

    // item monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_sample(i_angle_count, i_time_ms);
            if (o_valid && i_ready) sb.check_speed(o_speed, o_limited);
        end
    end

    // result side back-pressure, mostly short stalls and now and then a long one
    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(input logic [ANGLE_BITS-1:0] angle, input logic [TIME_W-1:0] now_ms);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_angle_count <= angle;
        i_time_ms     <= now_ms;
        do @(posedge i_clk); while (!o_ready);
        sent_angle = angle;
        sent_time  = now_ms;
    endtask

    // sample relative to the previous one
    task automatic send_step(input int step, input int unsigned dt_ms);
        send_sample(ANGLE_BITS'(int'(sent_angle) + step), sent_time + dt_ms);
    endtask

    // mostly plausible motion, some near half turn steps, some arbitrary samples
    task automatic send_random();
        int r;
        int sgn;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            send_step(int'($urandom_range(0, 600)) - 300, $urandom_range(0, 140));
        end else if (r < 80) begin
            send_step(int'($urandom_range(0, 4095)), $urandom_range(0, 20));
        end else if (r < 90) begin
            sgn = $urandom_range(0, 1) ? 1 : -1;
            send_step(sgn * int'($urandom_range(2046, 2050)), $urandom_range(0, 3));
        end else begin
            send_sample(ANGLE_BITS'($urandom()), $urandom());
        end
    endtask

    // lower valid and hold off until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned gain, input int unsigned limit,
                             input int unsigned minp, input int unsigned maxp);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        idx = '{REG_FILTER_GAIN, REG_SPEED_LIMIT, REG_MIN_PERIOD, REG_MAX_PERIOD};
        val = '{CFG_DATA_W'(gain), CFG_DATA_W'(limit), CFG_DATA_W'(minp), CFG_DATA_W'(maxp)};
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            sb.set_register(idx[k], val[k]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // stimulus
    initial begin
        sb            = new();
        calm          = 1'b0;
        settings      = 1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_angle_count = '0;
        i_time_ms     = '0;
        sent_angle    = '0;
        sent_time     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: first sample, time wrap, half turns, period clamps
        send_sample(12'hFFF, 32'hFFFF_FFF0);
        send_sample(12'h000, 32'h0000_0004);
        send_sample(12'h800, 32'h0000_0005);
        send_sample(12'h000, 32'h0000_0005);
        send_sample(12'h801, 32'h0000_0006);
        send_sample(12'h801, 32'h8000_0006);
        send_sample(12'hAAA, 32'h8000_0007);
        send_sample(12'h555, 32'h8000_0008);
        send_sample(12'hFFF, 32'hFFFF_FFFF);
        send_sample(12'h000, 32'hFFFF_FFFF);
        drain();

        // full gain, widest clamp, zero period limits
        configure(65536, 24'hFF_FFFF, 0, 0);
        send_step(2048, 0);
        send_step(-2048, 1);
        send_step(-1, 200);
        send_step(0, 5);
        drain();

        // no smoothing weight, zero clamp, longest period
        configure(0, 0, 255, 255);
        send_step(1000, 1);
        send_step(-2047, 0);
        send_step(17, 130);
        drain();

        // gain above one, minimum above maximum
        configure(24'h01_FFFF, 8388608, 200, 10);
        send_step(2048, 2);
        send_step(-300, 40);
        send_step(1, 0);
        send_step(-2048, 9);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            int unsigned gain;
            int unsigned limit;
            case ($urandom_range(0, 3))
                0: gain = $urandom_range(0, 65536);
                1: gain = $urandom_range(0, 8000);
                2: gain = 65536;
                default: gain = $urandom_range(65537, 131071);
            endcase
            limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                : $urandom_range(0, 8388608);
            if (ph == 0)
                configure(RST_FILTER_GAIN, RST_SPEED_LIMIT, RST_MIN_PERIOD, RST_MAX_PERIOD);
            else
                configure(gain, limit, $urandom_range(0, 12), $urandom_range(0, 255));
            calm = (ph == 2);
            for (int n = 0; n < 100; n++) begin
                // let the pipeline run dry once in the middle of a phase
                if (ph == 3 && n == 50) drain();
                send_random();
            end
            drain();
            calm = 1'b0;
        end

        repeat (40) @(posedge i_clk);
        $display("run covered %0d samples across %0d register settings; %0d results were clamped",
                 sb.samples, settings, sb.clamps);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("angle_to_speed_estimator_unit_test: clean");
        else
            $display("angle_to_speed_estimator_unit_test: errors");
        $finish;
    end

endmodule
